/* src/e2h_pkg.sv */
package e2h_pkg;

	localparam int unsigned RA_BITS = 24;
	localparam int unsigned DEC_BITS = 24;
	localparam int unsigned DAY_BITS = 16;
	localparam int unsigned TOD_BITS = 24;
	localparam int unsigned REG_BITS = 24;
	localparam int unsigned ALT_BITS = 24;
	localparam int unsigned AZ_BITS = 24;
	localparam int unsigned CHG_BITS = 25;

	localparam int unsigned IN_DATA_BITS = 88;
	localparam int unsigned OUT_DATA_BITS = 104;

	localparam logic [1:0] CFG_LATITUDE = 2'd0;
	localparam logic [1:0] CFG_LONGITUDE = 2'd1;
	localparam logic [1:0] CFG_ALT_LIMIT = 2'd2;

	localparam logic [31:0] QUARTER = 32'h4000_0000;
	localparam logic [31:0] EIGHTH = 32'h2000_0000;
	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
	localparam logic [31:0] PI_Q30 = 32'd3373259426;

	localparam logic [127:0] C0_WIDE = ((128'd10046 << 64) + 128'd18000) / 128'd36000;
	localparam logic [127:0] C1_WIDE = ((128'd985647 << 64) + 128'd180000000) / 128'd360000000;
	localparam logic [63:0] LST_C0 = C0_WIDE[63:0];
	localparam logic [63:0] LST_C1 = C1_WIDE[63:0];

	localparam int unsigned QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [31:0] ha;
		logic [31:0] dec;
	} e2h_item_t;

	typedef struct packed {
		logic req;
		logic [31:0] angle;
	} e2h_sin_req_t;

	typedef struct packed {
		logic done;
		logic signed [31:0] value;
	} e2h_sin_rsp_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL,
		F_LON,
		F_TOD,
		F_RA,
		F_PUSH
	} e2h_front_state_t;

	typedef enum logic [3:0] {
		SN_IDLE,
		SN_RAD,
		SN_RND,
		SN_SQ,
		SN_INIT,
		SN_TM,
		SN_RC,
		SN_RM,
		SN_FIX,
		SN_FIN
	} e2h_sine_state_t;

	typedef enum logic [4:0] {
		B_IDLE,
		B_SD,
		B_CD,
		B_SL,
		B_CL,
		B_CH,
		B_SH,
		B_P1,
		B_P2,
		B_P3,
		B_P4,
		B_P5,
		B_ASTEP,
		B_ASIN,
		B_AEND,
		B_CA,
		B_P6,
		B_P7,
		B_P8,
		B_DIVS,
		B_DIV,
		B_DEND,
		B_OUT
	} e2h_back_state_t;

	function automatic logic [7:0] series_div(input logic want_cos, input logic [2:0] k);
		logic [7:0] d;
		unique case ({want_cos, k})
			4'b0001: d = 8'd6;
			4'b0010: d = 8'd20;
			4'b0011: d = 8'd42;
			4'b0100: d = 8'd72;
			4'b0101: d = 8'd110;
			4'b0110: d = 8'd156;
			4'b0111: d = 8'd210;
			4'b1001: d = 8'd2;
			4'b1010: d = 8'd12;
			4'b1011: d = 8'd30;
			4'b1100: d = 8'd56;
			4'b1101: d = 8'd90;
			4'b1110: d = 8'd132;
			4'b1111: d = 8'd182;
			default: d = 8'd1;
		endcase
		return d;
	endfunction

	function automatic logic [31:0] series_rcp(input logic want_cos, input logic [2:0] k);
		logic [31:0] m;
		unique case ({want_cos, k})
			4'b0001: m = 32'd715827882;
			4'b0010: m = 32'd214748364;
			4'b0011: m = 32'd102261126;
			4'b0100: m = 32'd59652323;
			4'b0101: m = 32'd39045157;
			4'b0110: m = 32'd27531841;
			4'b0111: m = 32'd20452225;
			4'b1001: m = 32'd2147483648;
			4'b1010: m = 32'd357913941;
			4'b1011: m = 32'd143165576;
			4'b1100: m = 32'd76695844;
			4'b1101: m = 32'd47721858;
			4'b1110: m = 32'd32537631;
			4'b1111: m = 32'd23598721;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

/* src/e2h_front.sv */
module e2h_front #(
	parameter int ANGLE_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [e2h_pkg::RA_BITS-1:0]          right_ascension,
	input  logic signed [e2h_pkg::DEC_BITS-1:0]  declination,
	input  logic [e2h_pkg::DAY_BITS-1:0]         day_count,
	input  logic [e2h_pkg::TOD_BITS-1:0]         time_of_day,
	input  logic signed [e2h_pkg::REG_BITS-1:0]  longitude,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output e2h_pkg::e2h_item_t                   out_item
);

	localparam int LST_SHIFT = 64 - ANGLE_BITS;
	localparam int Q32_SHIFT = 32 - ANGLE_BITS;
	localparam int CNT_BITS = $clog2(e2h_pkg::DAY_BITS);

	e2h_pkg::e2h_front_state_t state_q, state_d;

	logic [e2h_pkg::RA_BITS-1:0] ra_q;
	logic [31:0] dec_q;
	logic [e2h_pkg::DAY_BITS-1:0] day_q;
	logic [e2h_pkg::TOD_BITS-1:0] tod_q;
	logic [63:0] acc_q;
	logic [63:0] c1_q;
	logic [CNT_BITS-1:0] cnt_q;

	logic accept;
	logic [63:0] lon_term;
	logic [63:0] ra_term;
	logic [31:0] dec_ext;

	assign accept = in_valid && in_ready;
	assign lon_term = {{(64-e2h_pkg::REG_BITS){longitude[e2h_pkg::REG_BITS-1]}}, longitude}
		<< LST_SHIFT;
	assign ra_term = {{(64-e2h_pkg::RA_BITS){1'b0}}, ra_q} << LST_SHIFT;
	assign dec_ext = {{(32-e2h_pkg::DEC_BITS){declination[e2h_pkg::DEC_BITS-1]}}, declination}
		<< Q32_SHIFT;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			e2h_pkg::F_IDLE: if (accept) state_d = e2h_pkg::F_MUL;
			e2h_pkg::F_MUL: if (cnt_q == CNT_BITS'(e2h_pkg::DAY_BITS - 1)) state_d = e2h_pkg::F_LON;
			e2h_pkg::F_LON: state_d = e2h_pkg::F_TOD;
			e2h_pkg::F_TOD: state_d = e2h_pkg::F_RA;
			e2h_pkg::F_RA: state_d = e2h_pkg::F_PUSH;
			e2h_pkg::F_PUSH: if (out_ready) state_d = e2h_pkg::F_IDLE;
			default: state_d = e2h_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == e2h_pkg::F_IDLE);
		out_valid = (state_q == e2h_pkg::F_PUSH);
		out_item.ha = acc_q[63:32];
		out_item.dec = dec_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= e2h_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			e2h_pkg::F_IDLE: begin
				if (accept) begin
					ra_q <= right_ascension;
					dec_q <= dec_ext;
					day_q <= day_count;
					tod_q <= time_of_day;
					acc_q <= e2h_pkg::LST_C0;
					c1_q <= e2h_pkg::LST_C1;
					cnt_q <= '0;
				end
			end
			e2h_pkg::F_MUL: begin
				if (day_q[0]) acc_q <= acc_q + c1_q;
				c1_q <= c1_q << 1;
				day_q <= day_q >> 1;
				cnt_q <= cnt_q + 1'b1;
			end
			e2h_pkg::F_LON: acc_q <= acc_q + lon_term;
			e2h_pkg::F_TOD: acc_q <= acc_q + {tod_q, 40'd0};
			e2h_pkg::F_RA: acc_q <= acc_q - ra_term;
			default: ;
		endcase
	end

endmodule

/* src/e2h_queue.sv */
module e2h_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  e2h_pkg::e2h_item_t in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output e2h_pkg::e2h_item_t out_item
);

	localparam int PTR_BITS = $clog2(e2h_pkg::QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(e2h_pkg::QUEUE_DEPTH + 1);

	e2h_pkg::e2h_item_t mem_q [e2h_pkg::QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wptr_q, rptr_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != CNT_BITS'(e2h_pkg::QUEUE_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_item = mem_q[rptr_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= in_item;
	end

endmodule

/* src/e2h_sine.sv */
module e2h_sine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  e2h_pkg::e2h_sin_req_t req,
	output e2h_pkg::e2h_sin_rsp_t rsp
);

	e2h_pkg::e2h_sine_state_t state_q, state_d;

	logic [29:0] x_q;
	logic wc_q, neg_q;
	logic [63:0] prod_q;
	logic [31:0] rad_q, x2_q, t_q, p_q;
	logic signed [33:0] sum_q;
	logic [2:0] k_q;

	logic start;
	logic big;
	logic [30:0] fold;
	logic [31:0] mul_a, mul_b;
	logic [7:0] div_d;
	logic [31:0] q_est;
	logic [39:0] q_back;
	logic [32:0] rem;
	logic [31:0] q_fix;
	logic signed [33:0] clamp;

	assign start = (state_q == e2h_pkg::SN_IDLE) && req.req;
	assign big = ({2'b00, req.angle[29:0]} > e2h_pkg::EIGHTH);
	assign fold = big ? (31'(e2h_pkg::QUARTER) - {1'b0, req.angle[29:0]})
		: {1'b0, req.angle[29:0]};
	assign div_d = e2h_pkg::series_div(wc_q, k_q);
	assign q_est = prod_q[63:32];
	assign q_back = q_est * div_d;
	assign rem = {1'b0, p_q} - q_back[32:0];
	assign q_fix = (rem >= {25'd0, div_d}) ? q_est + 1'b1 : q_est;

	always_comb begin
		mul_a = t_q;
		mul_b = x2_q;
		unique case (state_q)
			e2h_pkg::SN_RAD: begin
				mul_a = {2'b00, x_q};
				mul_b = e2h_pkg::PI_Q30;
			end
			e2h_pkg::SN_SQ: begin
				mul_a = rad_q;
				mul_b = rad_q;
			end
			e2h_pkg::SN_RM: begin
				mul_a = p_q;
				mul_b = e2h_pkg::series_rcp(wc_q, k_q);
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			e2h_pkg::SN_IDLE: if (req.req) state_d = e2h_pkg::SN_RAD;
			e2h_pkg::SN_RAD: state_d = e2h_pkg::SN_RND;
			e2h_pkg::SN_RND: state_d = e2h_pkg::SN_SQ;
			e2h_pkg::SN_SQ: state_d = e2h_pkg::SN_INIT;
			e2h_pkg::SN_INIT: state_d = e2h_pkg::SN_TM;
			e2h_pkg::SN_TM: state_d = e2h_pkg::SN_RC;
			e2h_pkg::SN_RC: state_d = e2h_pkg::SN_RM;
			e2h_pkg::SN_RM: state_d = e2h_pkg::SN_FIX;
			e2h_pkg::SN_FIX: state_d = (k_q == 3'd7) ? e2h_pkg::SN_FIN : e2h_pkg::SN_TM;
			e2h_pkg::SN_FIN: state_d = e2h_pkg::SN_IDLE;
			default: state_d = e2h_pkg::SN_IDLE;
		endcase
	end

	always_comb begin
		if (sum_q < 0) clamp = '0;
		else if (sum_q > $signed({2'b00, e2h_pkg::ONE_Q30})) clamp = {2'b00, e2h_pkg::ONE_Q30};
		else clamp = sum_q;
		rsp.done = (state_q == e2h_pkg::SN_FIN);
		rsp.value = neg_q ? -clamp[31:0] : clamp[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= e2h_pkg::SN_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= fold[29:0];
			wc_q <= req.angle[30] ^ big;
			neg_q <= req.angle[31];
		end
		unique case (state_q)
			e2h_pkg::SN_RAD, e2h_pkg::SN_SQ, e2h_pkg::SN_TM, e2h_pkg::SN_RM:
				prod_q <= mul_a * mul_b;
			e2h_pkg::SN_RND: rad_q <= 32'((prod_q + 64'h4000_0000) >> 31);
			e2h_pkg::SN_INIT: begin
				x2_q <= 32'((prod_q + 64'h2000_0000) >> 30);
				t_q <= wc_q ? e2h_pkg::ONE_Q30 : rad_q;
				sum_q <= wc_q ? {2'b00, e2h_pkg::ONE_Q30} : {2'b00, rad_q};
				k_q <= 3'd1;
			end
			e2h_pkg::SN_RC: p_q <= 32'((prod_q + 64'h2000_0000) >> 30);
			e2h_pkg::SN_FIX: begin
				t_q <= q_fix;
				sum_q <= k_q[0] ? sum_q - $signed({2'b00, q_fix}) : sum_q + $signed({2'b00, q_fix});
				k_q <= k_q + 1'b1;
			end
			default: ;
		endcase
	end

endmodule

/* src/e2h_back.sv */
module e2h_back #(
	parameter int ANGLE_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  e2h_pkg::e2h_item_t                   in_item,
	input  logic signed [e2h_pkg::REG_BITS-1:0]  latitude,
	input  logic signed [e2h_pkg::REG_BITS-1:0]  altitude_limit,
	output e2h_pkg::e2h_sin_req_t                sin_req,
	input  e2h_pkg::e2h_sin_rsp_t                sin_rsp,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [e2h_pkg::ALT_BITS-1:0]  altitude,
	output logic [e2h_pkg::AZ_BITS-1:0]          azimuth,
	output logic signed [e2h_pkg::CHG_BITS-1:0]  altitude_change,
	output logic signed [e2h_pkg::CHG_BITS-1:0]  azimuth_change,
	output logic                                 below_horizon
);

	localparam int SH = 32 - ANGLE_BITS;
	localparam logic [33:0] HALF = (34'd1 << SH) >> 1;
	localparam logic [33:0] AB_MASK = (34'd1 << ANGLE_BITS) - 34'd1;

	e2h_pkg::e2h_back_state_t state_q, state_d;

	logic [31:0] ha_q, dec_q;
	logic signed [31:0] sd_q, cd_q, sl_q, cl_q, ch_q, ca_q;
	logic sh_pos_q;
	logic [61:0] mp_q;
	logic mneg_q;
	logic signed [31:0] m1_q, m2_q, sa_q, alt_q, b2_q;
	logic signed [32:0] b1_q;
	logic [31:0] am_q, th_q, az_q;
	logic asg_q, pass2_q;
	logic [4:0] bit_q;
	logic [30:0] rem_q, dv_q;
	logic [29:0] quo_q;
	logic [4:0] dcnt_q;
	logic out_valid_q;
	logic [e2h_pkg::ALT_BITS-1:0] last_alt_q;
	logic [e2h_pkg::AZ_BITS-1:0] last_az_q;

	logic [31:0] lat32;
	logic signed [31:0] ma, mb;
	logic [30:0] ma_abs, mb_abs;
	logic signed [31:0] rnd;
	logic [61:0] rnd_sum;
	logic [31:0] cand;
	logic cand_over;
	logic signed [32:0] sa_sum;
	logic signed [32:0] asin;
	logic [31:0] az_base;
	logic [32:0] n_abs;
	logic [30:0] d_abs;
	logic [31:0] rs;
	logic out_load;
	logic signed [33:0] alt_r;
	logic [33:0] az_r;
	logic [e2h_pkg::ALT_BITS-1:0] alt_o;
	logic [e2h_pkg::AZ_BITS-1:0] az_o;

	assign lat32 = {{(32-e2h_pkg::REG_BITS){latitude[e2h_pkg::REG_BITS-1]}}, latitude} << SH;
	assign ma_abs = ma[31] ? 31'(-ma) : ma[30:0];
	assign mb_abs = mb[31] ? 31'(-mb) : mb[30:0];
	assign rnd_sum = mp_q + 62'h2000_0000;
	assign rnd = mneg_q ? -$signed({1'b0, rnd_sum[60:30]}) : $signed({1'b0, rnd_sum[60:30]});
	assign cand = th_q | (32'd1 << bit_q);
	assign cand_over = (cand > e2h_pkg::QUARTER);
	assign sa_sum = 33'(m1_q) + 33'(rnd);
	assign asin = asg_q ? -$signed({1'b0, th_q}) : $signed({1'b0, th_q});
	assign az_base = e2h_pkg::QUARTER - asin[31:0];
	assign n_abs = b1_q[32] ? 33'(-b1_q) : b1_q;
	assign d_abs = b2_q[31] ? 31'(-b2_q) : b2_q[30:0];
	assign rs = {rem_q, 1'b0};
	assign out_load = (state_q == e2h_pkg::B_OUT) && (!out_valid_q || out_ready);
	assign alt_r = ($signed({{2{alt_q[31]}}, alt_q}) + $signed(HALF)) >>> SH;
	assign az_r = ((({2'b00, az_q}) + HALF) >> SH) & AB_MASK;
	assign alt_o = alt_r[e2h_pkg::ALT_BITS-1:0];
	assign az_o = az_r[e2h_pkg::AZ_BITS-1:0];

	always_comb begin
		ma = sd_q;
		mb = sl_q;
		unique case (state_q)
			e2h_pkg::B_P2: begin
				ma = cd_q;
				mb = cl_q;
			end
			e2h_pkg::B_P4: begin
				ma = m2_q;
				mb = ch_q;
			end
			e2h_pkg::B_P6: begin
				ma = sa_q;
				mb = sl_q;
			end
			e2h_pkg::B_P7: begin
				ma = ca_q;
				mb = cl_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			e2h_pkg::B_IDLE: if (in_valid) state_d = e2h_pkg::B_SD;
			e2h_pkg::B_SD: if (sin_rsp.done) state_d = e2h_pkg::B_CD;
			e2h_pkg::B_CD: if (sin_rsp.done) state_d = e2h_pkg::B_SL;
			e2h_pkg::B_SL: if (sin_rsp.done) state_d = e2h_pkg::B_CL;
			e2h_pkg::B_CL: if (sin_rsp.done) state_d = e2h_pkg::B_CH;
			e2h_pkg::B_CH: if (sin_rsp.done) state_d = e2h_pkg::B_SH;
			e2h_pkg::B_SH: if (sin_rsp.done) state_d = e2h_pkg::B_P1;
			e2h_pkg::B_P1: state_d = e2h_pkg::B_P2;
			e2h_pkg::B_P2: state_d = e2h_pkg::B_P3;
			e2h_pkg::B_P3: state_d = e2h_pkg::B_P4;
			e2h_pkg::B_P4: state_d = e2h_pkg::B_P5;
			e2h_pkg::B_P5: state_d = e2h_pkg::B_ASTEP;
			e2h_pkg::B_ASTEP: begin
				if (!cand_over) state_d = e2h_pkg::B_ASIN;
				else if (bit_q == '0) state_d = e2h_pkg::B_AEND;
			end
			e2h_pkg::B_ASIN: begin
				if (sin_rsp.done) state_d = (bit_q == '0) ? e2h_pkg::B_AEND : e2h_pkg::B_ASTEP;
			end
			e2h_pkg::B_AEND: state_d = pass2_q ? e2h_pkg::B_OUT : e2h_pkg::B_CA;
			e2h_pkg::B_CA: if (sin_rsp.done) state_d = e2h_pkg::B_P6;
			e2h_pkg::B_P6: state_d = e2h_pkg::B_P7;
			e2h_pkg::B_P7: state_d = e2h_pkg::B_P8;
			e2h_pkg::B_P8: state_d = e2h_pkg::B_DIVS;
			e2h_pkg::B_DIVS: begin
				if (b2_q == '0) state_d = e2h_pkg::B_OUT;
				else if (n_abs >= {2'b00, d_abs}) state_d = e2h_pkg::B_ASTEP;
				else state_d = e2h_pkg::B_DIV;
			end
			e2h_pkg::B_DIV: if (dcnt_q == 5'd29) state_d = e2h_pkg::B_DEND;
			e2h_pkg::B_DEND: state_d = e2h_pkg::B_ASTEP;
			e2h_pkg::B_OUT: if (out_load) state_d = e2h_pkg::B_IDLE;
			default: state_d = e2h_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == e2h_pkg::B_IDLE);
		sin_req.req = 1'b1;
		sin_req.angle = dec_q;
		unique case (state_q)
			e2h_pkg::B_SD: sin_req.angle = dec_q;
			e2h_pkg::B_CD: sin_req.angle = dec_q + e2h_pkg::QUARTER;
			e2h_pkg::B_SL: sin_req.angle = lat32;
			e2h_pkg::B_CL: sin_req.angle = lat32 + e2h_pkg::QUARTER;
			e2h_pkg::B_CH: sin_req.angle = ha_q + e2h_pkg::QUARTER;
			e2h_pkg::B_SH: sin_req.angle = ha_q;
			e2h_pkg::B_ASIN: sin_req.angle = cand;
			e2h_pkg::B_CA: sin_req.angle = alt_q + e2h_pkg::QUARTER;
			default: sin_req.req = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= e2h_pkg::B_IDLE;
			out_valid_q <= 1'b0;
			last_alt_q <= '0;
			last_az_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
				last_alt_q <= alt_o;
				last_az_q <= az_o;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			e2h_pkg::B_IDLE: begin
				if (in_valid) begin
					ha_q <= in_item.ha;
					dec_q <= in_item.dec;
				end
			end
			e2h_pkg::B_SD: if (sin_rsp.done) sd_q <= sin_rsp.value;
			e2h_pkg::B_CD: if (sin_rsp.done) cd_q <= sin_rsp.value;
			e2h_pkg::B_SL: if (sin_rsp.done) sl_q <= sin_rsp.value;
			e2h_pkg::B_CL: if (sin_rsp.done) cl_q <= sin_rsp.value;
			e2h_pkg::B_CH: if (sin_rsp.done) ch_q <= sin_rsp.value;
			e2h_pkg::B_SH: if (sin_rsp.done) sh_pos_q <= (sin_rsp.value > 0);
			e2h_pkg::B_CA: if (sin_rsp.done) ca_q <= sin_rsp.value;
			e2h_pkg::B_P1, e2h_pkg::B_P4, e2h_pkg::B_P6: begin
				mp_q <= ma_abs * mb_abs;
				mneg_q <= ma[31] ^ mb[31];
			end
			e2h_pkg::B_P2: begin
				m1_q <= rnd;
				mp_q <= ma_abs * mb_abs;
				mneg_q <= ma[31] ^ mb[31];
			end
			e2h_pkg::B_P3: m2_q <= rnd;
			e2h_pkg::B_P5: begin
				if (sa_sum > $signed({1'b0, e2h_pkg::ONE_Q30})) sa_q <= e2h_pkg::ONE_Q30;
				else if (sa_sum < -$signed({1'b0, e2h_pkg::ONE_Q30})) sa_q <= -e2h_pkg::ONE_Q30;
				else sa_q <= sa_sum[31:0];
				if (sa_sum > $signed({1'b0, e2h_pkg::ONE_Q30})
					|| sa_sum < -$signed({1'b0, e2h_pkg::ONE_Q30})) begin
					am_q <= e2h_pkg::ONE_Q30;
				end else begin
					am_q <= sa_sum[32] ? 32'(-sa_sum) : sa_sum[31:0];
				end
				asg_q <= sa_sum[32];
				th_q <= '0;
				bit_q <= 5'd30;
				pass2_q <= 1'b0;
			end
			e2h_pkg::B_ASTEP: begin
				if (cand_over && bit_q != '0) bit_q <= bit_q - 1'b1;
			end
			e2h_pkg::B_ASIN: begin
				if (sin_rsp.done) begin
					if (sin_rsp.value <= $signed(am_q)) th_q <= cand;
					if (bit_q != '0) bit_q <= bit_q - 1'b1;
				end
			end
			e2h_pkg::B_AEND: begin
				if (!pass2_q) alt_q <= asin[31:0];
				else az_q <= sh_pos_q ? (32'd0 - az_base) : az_base;
			end
			e2h_pkg::B_P7: begin
				b1_q <= 33'(sd_q) - 33'(rnd);
				mp_q <= ma_abs * mb_abs;
				mneg_q <= ma[31] ^ mb[31];
			end
			e2h_pkg::B_P8: b2_q <= rnd;
			e2h_pkg::B_DIVS: begin
				asg_q <= b1_q[32] ^ b2_q[31];
				th_q <= '0;
				bit_q <= 5'd30;
				pass2_q <= 1'b1;
				am_q <= e2h_pkg::ONE_Q30;
				rem_q <= n_abs[30:0];
				dv_q <= d_abs;
				quo_q <= '0;
				dcnt_q <= '0;
				if (b2_q == '0) az_q <= '0;
			end
			e2h_pkg::B_DIV: begin
				if (rs >= {1'b0, dv_q}) begin
					rem_q <= 31'(rs - {1'b0, dv_q});
					quo_q <= {quo_q[28:0], 1'b1};
				end else begin
					rem_q <= rs[30:0];
					quo_q <= {quo_q[28:0], 1'b0};
				end
				dcnt_q <= dcnt_q + 1'b1;
			end
			e2h_pkg::B_DEND: am_q <= {2'b00, quo_q};
			e2h_pkg::B_OUT: begin
				if (out_load) begin
					altitude <= alt_o;
					azimuth <= az_o;
					altitude_change <= $signed({alt_o[e2h_pkg::ALT_BITS-1], alt_o})
						- $signed({last_alt_q[e2h_pkg::ALT_BITS-1], last_alt_q});
					azimuth_change <= $signed({1'b0, az_o} - {1'b0, last_az_q});
					below_horizon <= ($signed(alt_o) <= altitude_limit);
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

/* src/equatorial_to_horizontal.sv */
// Converts a target's right ascension and declination, with a day count and
// time of day, to altitude and azimuth for the observer set by the latitude
// and longitude registers. Angles use 2^ANGLE_BITS units per turn. The front
// end takes a word, forms the day term of sidereal time by shift-add, and
// hands the hour angle to a two-word queue; the back end then works each word
// through the single shared sine unit, which also runs the arcsine searches,
// up to 31 evaluations each. Results wait in an output register while the next
// word is already at work. Write configuration only while the block is idle.
module equatorial_to_horizontal #(
	parameter int ANGLE_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// right_ascension, declination, day_count, time_of_day
	input  logic [e2h_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// altitude, azimuth, altitude_change, azimuth_change, zero fill
	output logic [e2h_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata,
	// below_horizon
	output logic                                  m_axis_tuser,
	input  logic                                  cfg_we,
	input  logic [1:0]                            cfg_index,
	input  logic [e2h_pkg::REG_BITS-1:0]          cfg_data
);

	logic signed [e2h_pkg::REG_BITS-1:0] latitude_q, longitude_q, limit_q;

	logic fq_valid, fq_ready, qb_valid, qb_ready;
	e2h_pkg::e2h_item_t fq_item, qb_item;
	e2h_pkg::e2h_sin_req_t sin_req;
	e2h_pkg::e2h_sin_rsp_t sin_rsp;

	logic signed [e2h_pkg::ALT_BITS-1:0] altitude;
	logic [e2h_pkg::AZ_BITS-1:0] azimuth;
	logic signed [e2h_pkg::CHG_BITS-1:0] altitude_change, azimuth_change;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latitude_q <= '0;
			longitude_q <= '0;
			limit_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				e2h_pkg::CFG_LATITUDE: latitude_q <= cfg_data;
				e2h_pkg::CFG_LONGITUDE: longitude_q <= cfg_data;
				e2h_pkg::CFG_ALT_LIMIT: limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	e2h_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.right_ascension (s_axis_tdata[23:0]),
		.declination     (s_axis_tdata[47:24]),
		.day_count       (s_axis_tdata[63:48]),
		.time_of_day     (s_axis_tdata[87:64]),
		.longitude       (longitude_q),
		.out_valid       (fq_valid),
		.out_ready       (fq_ready),
		.out_item        (fq_item)
	);

	e2h_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_item   (fq_item),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_item  (qb_item)
	);

	e2h_sine u_sine (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sin_req),
		.rsp    (sin_rsp)
	);

	e2h_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (qb_valid),
		.in_ready        (qb_ready),
		.in_item         (qb_item),
		.latitude        (latitude_q),
		.altitude_limit  (limit_q),
		.sin_req         (sin_req),
		.sin_rsp         (sin_rsp),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.altitude        (altitude),
		.azimuth         (azimuth),
		.altitude_change (altitude_change),
		.azimuth_change  (azimuth_change),
		.below_horizon   (m_axis_tuser)
	);

	assign m_axis_tdata = {6'd0, azimuth_change, altitude_change, azimuth, altitude};

endmodule

/* src/e2h_checker.sv */
module e2h_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [103:0] m_axis_tdata
);

	logic [23:0] alt_seen_q, az_seen_q;
	logic out_accept;
	logic [24:0] alt_expect, az_expect;

	assign out_accept = m_axis_tvalid && m_axis_tready;
	assign alt_expect = {m_axis_tdata[23], m_axis_tdata[23:0]} - {alt_seen_q[23], alt_seen_q};
	assign az_expect = {1'b0, m_axis_tdata[47:24]} - {1'b0, az_seen_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_seen_q <= '0;
			az_seen_q <= '0;
		end else if (out_accept) begin
			alt_seen_q <= m_axis_tdata[23:0];
			az_seen_q <= m_axis_tdata[47:24];
		end
	end

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result word dropped while stalled");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	a_alt_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_accept |-> m_axis_tdata[72:48] == alt_expect)
		else $error("altitude change does not match previous result");

	a_az_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_accept |-> m_axis_tdata[97:73] == az_expect)
		else $error("azimuth change does not match previous result");

endmodule

bind equatorial_to_horizontal e2h_checker u_e2h_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

/* sim/tb_equatorial_to_horizontal.sv */
module tb_equatorial_to_horizontal;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [23:0] tod;
		logic [15:0] days;
		logic [23:0] dec;
		logic [23:0] ra;
	} target_t;

	typedef struct packed {
		logic        below;
		logic [24:0] az_chg;
		logic [24:0] alt_chg;
		logic [23:0] az;
		logic [23:0] alt;
	} pointing_t;

	localparam longint unsigned PI_Q = 64'd3373259426;
	localparam longint ONE_Q = 64'sd1 << 30;
	localparam logic [31:0] QTURN = 32'h4000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [e2h_pkg::IN_DATA_BITS-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [e2h_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = e2h_pkg::CFG_LATITUDE;
	logic [e2h_pkg::REG_BITS-1:0] cfg_data = '0;

	target_t pending_targets[$];
	pointing_t expected_pointings[$];
	logic [23:0] lat_reg = '0, lon_reg = '0, limit_reg = '0;
	logic [23:0] prev_alt = '0, prev_az = '0;
	int errors = 0;
	int results_seen = 0;
	int burst_left = 0, gap_left = 0;
	int hold_left = 0, mode_left = 0;
	bit rx_free = 1'b0, long_hold_done = 1'b0;
	bit in_taken = 1'b0;

	equatorial_to_horizontal DUT (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint unsigned series_q30(logic [31:0] x, bit want_cos);
		longint unsigned rad, x2, t, d;
		longint acc;
		rad = (64'(x) * PI_Q + (64'd1 << 30)) >> 31;
		x2 = (rad * rad + (64'd1 << 29)) >> 30;
		t = want_cos ? (64'd1 << 30) : rad;
		acc = longint'(t);
		for (int k = 1; k <= 7; k++) begin
			d = want_cos ? 64'((2 * k - 1) * (2 * k)) : 64'((2 * k) * (2 * k + 1));
			t = ((t * x2 + (64'd1 << 29)) >> 30) / d;
			if (k % 2 == 1) acc -= longint'(t);
			else acc += longint'(t);
		end
		if (acc < 0) acc = 0;
		if (acc > ONE_Q) acc = ONE_Q;
		return longint'(acc);
	endfunction

	function automatic longint sin_q30(logic [31:0] a);
		logic [31:0] r;
		longint unsigned s, c, v;
		r = {2'b00, a[29:0]};
		if (r <= 32'h2000_0000) begin
			s = series_q30(r, 1'b0);
			c = series_q30(r, 1'b1);
		end else begin
			s = series_q30(QTURN - r, 1'b1);
			c = series_q30(QTURN - r, 1'b0);
		end
		v = a[30] ? c : s;
		return a[31] ? -longint'(v) : longint'(v);
	endfunction

	function automatic longint cos_q30(logic [31:0] a);
		return sin_q30(a + QTURN);
	endfunction

	function automatic longint asin_turn(longint s);
		longint m;
		logic [31:0] th, cand;
		m = (s < 0) ? -s : s;
		th = '0;
		for (int i = 30; i >= 0; i--) begin
			cand = th | (32'd1 << i);
			if (cand <= QTURN && sin_q30(cand) <= m) th = cand;
		end
		return (s < 0) ? -longint'(th) : longint'(th);
	endfunction

	function automatic longint mul_q30(longint a, longint b);
		longint unsigned ua, ub, p;
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		p = (ua * ub + (64'd1 << 29)) >> 30;
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint to_out_units(longint v);
		longint unsigned u;
		u = (longint'(v + (64'sd1 << 32)) + 64'd128) >> 8;
		return longint'(u) - (64'sd1 << 24);
	endfunction

	function automatic pointing_t point_target(target_t t);
		logic [127:0] wide;
		logic [63:0] c0, c1, lst;
		logic [31:0] ha, dec32, lat32, alt32, az32;
		longint sd, cd, sl, cl, ch, sa, ca, b1, b2, altt, alt_o, az_o, ratio;
		longint unsigned n, d;
		pointing_t p;
		wide = ((128'd10046 << 64) + 128'd18000) / 128'd36000;
		c0 = wide[63:0];
		wide = ((128'd985647 << 64) + 128'd180000000) / 128'd360000000;
		c1 = wide[63:0];
		lst = c0 + c1 * 64'(t.days) + (64'(signed'(lon_reg)) << 40) + (64'(t.tod) << 40);
		lst = lst - (64'(t.ra) << 40);
		ha = lst[63:32];
		dec32 = {t.dec, 8'h00};
		lat32 = {lat_reg, 8'h00};
		sd = sin_q30(dec32);
		cd = cos_q30(dec32);
		sl = sin_q30(lat32);
		cl = cos_q30(lat32);
		ch = cos_q30(ha);
		sa = mul_q30(sd, sl) + mul_q30(mul_q30(cd, cl), ch);
		if (sa > ONE_Q) sa = ONE_Q;
		if (sa < -ONE_Q) sa = -ONE_Q;
		altt = asin_turn(sa);
		alt32 = altt[31:0];
		ca = cos_q30(alt32);
		b1 = sd - mul_q30(sa, sl);
		b2 = mul_q30(ca, cl);
		if (b2 == 0) begin
			az32 = '0;
		end else begin
			n = (b1 < 0) ? -b1 : b1;
			d = (b2 < 0) ? -b2 : b2;
			ratio = (n >= d) ? ONE_Q : longint'((n << 30) / d);
			if ((b1 < 0) != (b2 < 0)) ratio = -ratio;
			az32 = QTURN - 32'(ratio == 0 ? 0 : asin_turn(ratio));
			if (sin_q30(ha) > 0) az32 = 32'd0 - az32;
		end
		alt_o = to_out_units(altt);
		az_o = to_out_units(longint'({32'd0, az32}));
		p.alt = alt_o[23:0];
		p.az = az_o[23:0];
		p.alt_chg = 25'(longint'(signed'(p.alt)) - longint'(signed'(prev_alt)));
		p.az_chg = 25'(longint'(p.az) - longint'(prev_az));
		p.below = (signed'(p.alt) <= signed'(limit_reg));
		return p;
	endfunction

	always @(negedge clk) begin
		if (s_axis_tvalid && !in_taken) begin
			// hold the offered word until it is taken
		end else if (gap_left > 0) begin
			s_axis_tvalid <= 1'b0;
			gap_left--;
		end else if (pending_targets.size() > 0) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= pending_targets[0];
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 12);
				case ($urandom_range(0, 9))
					0: gap_left = $urandom_range(200, 3000);
					1, 2, 3: gap_left = 0;
					default: gap_left = $urandom_range(1, 40);
				endcase
			end
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (!long_hold_done && results_seen == 40) begin
			long_hold_done = 1'b1;
			hold_left = 12000;
		end
		if (mode_left == 0) begin
			mode_left = $urandom_range(50, 4000);
			rx_free = ($urandom_range(0, 2) == 0);
		end else begin
			mode_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= rx_free ? 1'b1 : ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		pointing_t got, want;
		in_taken = s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready && pending_targets.size() > 0) begin
			want = point_target(pending_targets.pop_front());
			prev_alt = want.alt;
			prev_az = want.az;
			expected_pointings.push_back(want);
		end
		if (m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			got = {m_axis_tuser, m_axis_tdata[97:0]};
			if (expected_pointings.size() == 0) begin
				$error("unexpected word %h", got);
				errors++;
			end else begin
				want = expected_pointings.pop_front();
				if (got.alt !== want.alt) begin
					$error("altitude exp %h got %h", want.alt, got.alt);
					errors++;
				end
				if (got.az !== want.az) begin
					$error("azimuth exp %h got %h", want.az, got.az);
					errors++;
				end
				if (got.alt_chg !== want.alt_chg) begin
					$error("altitude_change exp %h got %h", want.alt_chg, got.alt_chg);
					errors++;
				end
				if (got.az_chg !== want.az_chg) begin
					$error("azimuth_change exp %h got %h", want.az_chg, got.az_chg);
					errors++;
				end
				if (got.below !== want.below) begin
					$error("below_horizon exp %b got %b", want.below, got.below);
					errors++;
				end
			end
		end
	end

	task automatic write_regs(logic [23:0] lat, logic [23:0] lon, logic [23:0] lim);
		wait (pending_targets.size() == 0 && expected_pointings.size() == 0);
		repeat (50) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= e2h_pkg::CFG_LATITUDE;
		cfg_data <= lat;
		@(negedge clk);
		cfg_index <= e2h_pkg::CFG_LONGITUDE;
		cfg_data <= lon;
		@(negedge clk);
		cfg_index <= e2h_pkg::CFG_ALT_LIMIT;
		cfg_data <= lim;
		@(negedge clk);
		cfg_index <= 2'd3;
		cfg_data <= 24'($urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
		lat_reg = lat;
		lon_reg = lon;
		limit_reg = lim;
		@(negedge clk);
	endtask

	function automatic target_t random_target();
		target_t t;
		t.ra = 24'($urandom);
		t.dec = ($urandom_range(0, 9) == 0) ? 24'($urandom) :
			24'($urandom_range(0, 8388608) - 4194304);
		t.days = 16'($urandom);
		t.tod = 24'($urandom);
		return t;
	endfunction

	function automatic logic [23:0] random_angle(int lo, int hi);
		return 24'($urandom_range(0, hi - lo) + lo);
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_regs(24'd0, 24'd0, 24'd0);
		pending_targets.push_back('{24'd0, 16'd0, 24'd0, 24'd0});
		pending_targets.push_back('{24'hFFFFFF, 16'hFFFF, 24'h400000, 24'hFFFFFF});
		pending_targets.push_back('{24'h000000, 16'd0, 24'hC00000, 24'h800000});
		pending_targets.push_back('{24'h7FFFFF, 16'h8000, 24'h7FFFFF, 24'h123456});
		pending_targets.push_back('{24'h800000, 16'h0001, 24'h800000, 24'hABCDEF});
		pending_targets.push_back('{24'h400000, 16'h7FFF, 24'h000001, 24'h000001});
		write_regs(24'h400000, 24'h7FFFFF, 24'h400000);
		pending_targets.push_back('{24'd0, 16'd0, 24'd0, 24'd0});
		pending_targets.push_back('{24'h5A5A5A, 16'h1234, 24'h100000, 24'h3C0000});
		pending_targets.push_back('{24'hFFFFFF, 16'hFFFF, 24'hC00000, 24'hFFFFFF});
		write_regs(24'hC00000, 24'h800000, 24'hC00000);
		pending_targets.push_back('{24'd0, 16'd0, 24'd0, 24'd0});
		pending_targets.push_back('{24'hA5A5A5, 16'hEDCB, 24'hF00000, 24'h876543});
		pending_targets.push_back('{24'hFFFFFF, 16'hFFFF, 24'h400000, 24'h000000});
		write_regs(24'h200000, 24'hFFFFFF, 24'hFFFFFF);
		pending_targets.push_back('{24'h000000, 16'd0, 24'h200000, 24'h000000});
		pending_targets.push_back('{24'hFFFFFF, 16'hFFFF, 24'hE00000, 24'hFFFFFF});

		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 0) write_regs(24'h0A0000, 24'hF80000, 24'h000000);
			else if ($urandom_range(0, 4) == 0)
				write_regs(24'($urandom), 24'($urandom), 24'($urandom));
			else
				write_regs(random_angle(-4194304, 4194304), 24'($urandom),
					random_angle(-4194304, 4194304));
			repeat (108) pending_targets.push_back(random_target());
		end

		wait (pending_targets.size() == 0 && expected_pointings.size() == 0);
		repeat (3000) @(posedge clk);
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

	initial begin
		#100ms;
		$display("FAIL");
		$finish;
	end
endmodule

/* sim.f */
src/e2h_pkg.sv
src/e2h_front.sv
src/e2h_queue.sv
src/e2h_sine.sv
src/e2h_back.sv
src/equatorial_to_horizontal.sv
src/e2h_checker.sv
sim/tb_equatorial_to_horizontal.sv
